/* rtl/lsc_pkg.sv */
`default_nettype none
package lsc_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int IW          = COORD_WIDTH + 4;
    localparam int DW          = COORD_WIDTH + 1;
    localparam int PW          = DW + IW + 1;
    localparam int CNT_W       = $clog2(PW + 1);
    localparam int MAX_PASSES  = 8;
    localparam int PASS_W      = $clog2(MAX_PASSES + 1);

    localparam logic [3:0] LEFT  = 4'd1;
    localparam logic [3:0] RIGHT = 4'd2;
    localparam logic [3:0] ABOVE = 4'd4;
    localparam logic [3:0] BELOW = 4'd8;

    localparam logic [1:0] REG_LEFT   = 2'd0;
    localparam logic [1:0] REG_RIGHT  = 2'd1;
    localparam logic [1:0] REG_TOP    = 2'd2;
    localparam logic [1:0] REG_BOTTOM = 2'd3;

    typedef struct packed {
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] top;
        logic [7:0] bottom;
    } window_t;

    typedef struct packed {
        logic signed [IW-1:0] x0;
        logic signed [IW-1:0] y0;
        logic signed [IW-1:0] x1;
        logic signed [IW-1:0] y1;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [3:0]           c0;
        logic [3:0]           c1;
        logic [7:0]           colour;
    } entry_t;

    function automatic logic [3:0] region(logic signed [IW-1:0] x, logic signed [IW-1:0] y,
                                          window_t w);
        logic [3:0] c;
        c = 4'd0;
        if (x < $signed({{(IW-8){1'b0}}, w.left})) c = LEFT;
        else if (x > $signed({{(IW-8){1'b0}}, w.right})) c = RIGHT;
        if (y < $signed({{(IW-8){1'b0}}, w.top})) c = c | ABOVE;
        else if (y > $signed({{(IW-8){1'b0}}, w.bottom})) c = c | BELOW;
        return c;
    endfunction
endpackage
`default_nettype wire

/* rtl/lsc_front.sv */
`default_nettype none
module lsc_front (
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [71:0]     s_tdata,
    input  wire lsc_pkg::window_t win,
    input  wire logic            q_full,
    output logic                 q_push,
    output lsc_pkg::entry_t      q_entry
);
    logic signed [lsc_pkg::COORD_WIDTH-1:0] sx, sy, ex, ey;

    assign sx = s_tdata[15:0];
    assign sy = s_tdata[31:16];
    assign ex = s_tdata[47:32];
    assign ey = s_tdata[63:48];

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        q_entry.x0     = lsc_pkg::IW'(sx);
        q_entry.y0     = lsc_pkg::IW'(sy);
        q_entry.x1     = lsc_pkg::IW'(ex);
        q_entry.y1     = lsc_pkg::IW'(ey);
        q_entry.dx     = lsc_pkg::DW'(ex) - lsc_pkg::DW'(sx);
        q_entry.dy     = lsc_pkg::DW'(ey) - lsc_pkg::DW'(sy);
        q_entry.c0     = lsc_pkg::region(q_entry.x0, q_entry.y0, win);
        q_entry.c1     = lsc_pkg::region(q_entry.x1, q_entry.y1, win);
        q_entry.colour = s_tdata[71:64];
    end
endmodule
`default_nettype wire

/* rtl/lsc_queue.sv */
`default_nettype none
module lsc_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire lsc_pkg::entry_t push_entry,
    input  wire logic            pop,
    output lsc_pkg::entry_t      head,
    output logic                 full,
    output logic                 empty
);
    lsc_pkg::entry_t mem_reg [2];
    logic wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = count_reg == 2'd2;
    assign empty = count_reg == 2'd0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

/* rtl/lsc_div.sv */
`default_nettype none
module lsc_div (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [lsc_pkg::PW-1:0]  dividend,
    input  wire logic [lsc_pkg::DW-1:0]  divisor,
    output logic                         done,
    output logic [lsc_pkg::PW-1:0]       quotient
);
    logic [lsc_pkg::DW-1:0]    rem_reg;
    logic [lsc_pkg::PW-1:0]    quo_reg;
    logic [lsc_pkg::DW-1:0]    den_reg;
    logic [lsc_pkg::CNT_W-1:0] cnt_reg;
    logic                      busy_reg, done_reg;
    logic [lsc_pkg::DW:0]      trial;
    logic                      fits;

    assign trial    = {rem_reg, quo_reg[lsc_pkg::PW-1]};
    assign fits     = trial >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= fits ? lsc_pkg::DW'(trial - {1'b0, den_reg}) : lsc_pkg::DW'(trial);
            quo_reg <= {quo_reg[lsc_pkg::PW-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= lsc_pkg::CNT_W'(lsc_pkg::PW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == lsc_pkg::CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/lsc_back.sv */
`default_nettype none
module lsc_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire lsc_pkg::window_t win,
    input  wire lsc_pkg::entry_t head,
    input  wire logic            q_empty,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [39:0]          m_tdata,
    output logic [0:0]           m_tuser
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EVAL = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    localparam int IW = lsc_pkg::IW;
    localparam int DW = lsc_pkg::DW;
    localparam int PW = lsc_pkg::PW;

    logic [2:0]            state_reg;
    lsc_pkg::entry_t       seg_reg;
    logic [lsc_pkg::PASS_W-1:0] pass_reg;
    logic                  first_reg, yedge_reg, neg_reg, dzero_reg;
    logic signed [IW-1:0]  edge_reg;
    logic [DW-1:0]         ua_reg, ud_reg;
    logic [IW:0]           ub_reg;
    logic [PW-1:0]         prod;
    logic                  div_start, div_done;
    logic [PW-1:0]         div_q;
    logic                  valid_reg;
    logic [39:0]           data_reg;
    logic                  ok_reg;

    logic [3:0]            c;
    logic signed [IW-1:0]  ev;
    logic signed [DW-1:0]  a, d;
    logic signed [IW:0]    b;
    logic signed [IW-1:0]  qs, nx, ny;

    lsc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod),
        .divisor  (ud_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_pop     = state_reg == ST_IDLE && !q_empty;
    assign div_start = state_reg == ST_MUL;
    assign prod      = PW'(ua_reg) * PW'(ub_reg);
    assign m_tvalid  = valid_reg;
    assign m_tdata   = data_reg;
    assign m_tuser   = ok_reg;

    always_comb begin
        c = (seg_reg.c0 != 4'd0) ? seg_reg.c0 : seg_reg.c1;
        if ((c & lsc_pkg::ABOVE) != 4'd0) ev = $signed({{(IW-8){1'b0}}, win.top});
        else if ((c & lsc_pkg::BELOW) != 4'd0) ev = $signed({{(IW-8){1'b0}}, win.bottom});
        else if ((c & lsc_pkg::RIGHT) != 4'd0) ev = $signed({{(IW-8){1'b0}}, win.right});
        else ev = $signed({{(IW-8){1'b0}}, win.left});
        if ((c & (lsc_pkg::ABOVE | lsc_pkg::BELOW)) != 4'd0) begin
            a = seg_reg.dx;
            d = seg_reg.dy;
            b = (IW+1)'(ev) - (IW+1)'(seg_reg.y0);
        end else begin
            a = seg_reg.dy;
            d = seg_reg.dx;
            b = (IW+1)'(ev) - (IW+1)'(seg_reg.x0);
        end
        qs = dzero_reg ? '0 : (neg_reg ? -IW'(div_q) : IW'(div_q));
        if (yedge_reg) begin
            ny = edge_reg;
            nx = seg_reg.x0 + qs;
        end else begin
            nx = edge_reg;
            ny = seg_reg.y0 + qs;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                seg_reg  <= head;
                pass_reg <= '0;
            end
            ST_EVAL: begin
                first_reg <= seg_reg.c0 != 4'd0;
                yedge_reg <= (c & (lsc_pkg::ABOVE | lsc_pkg::BELOW)) != 4'd0;
                edge_reg  <= ev;
                neg_reg   <= a[DW-1] ^ b[IW] ^ d[DW-1];
                dzero_reg <= d == '0;
                ua_reg    <= a[DW-1] ? DW'(-a) : DW'(a);
                ub_reg    <= b[IW] ? (IW+1)'(-b) : (IW+1)'(b);
                ud_reg    <= d[DW-1] ? DW'(-d) : DW'(d);
            end
            ST_UPD: begin
                pass_reg <= pass_reg + 1'b1;
                if (first_reg) begin
                    seg_reg.x0 <= nx;
                    seg_reg.y0 <= ny;
                    seg_reg.c0 <= lsc_pkg::region(nx, ny, win);
                end else begin
                    seg_reg.x1 <= nx;
                    seg_reg.y1 <= ny;
                    seg_reg.c1 <= lsc_pkg::region(nx, ny, win);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: if (!q_empty) state_reg <= ST_EVAL;
                ST_EVAL: begin
                    if (seg_reg.c0 == 4'd0 && seg_reg.c1 == 4'd0) begin
                        ok_reg    <= 1'b1;
                        data_reg  <= {seg_reg.colour, seg_reg.y1[7:0], seg_reg.x1[7:0],
                                      seg_reg.y0[7:0], seg_reg.x0[7:0]};
                        valid_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end else if ((seg_reg.c0 & seg_reg.c1) != 4'd0 ||
                                 pass_reg == lsc_pkg::PASS_W'(lsc_pkg::MAX_PASSES)) begin
                        ok_reg    <= 1'b0;
                        data_reg  <= {seg_reg.colour, 32'd0};
                        valid_reg <= 1'b1;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: state_reg <= ST_DIV;
                ST_DIV: if (div_done) state_reg <= ST_UPD;
                ST_UPD: state_reg <= ST_EVAL;
                ST_OUT: begin
                    if (m_tready) begin
                        valid_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/line_segment_clipper.sv */
// channel | dir | fields
// s_      | in  | tdata: start_x, start_y, end_x, end_y, colour
// m_      | out | tdata: clip_start_x, clip_start_y, clip_end_x, clip_end_y, colour_out;
//         |     | tuser: accepted
// apb     | in  | window_left, window_right, window_top, window_bottom at 0x0..0xC
// Each clip pass runs the EVAL, MUL, DIV and UPD states, DIV waiting on the shift-subtract
// divider; an item takes up to eight passes in the back end.
// A two-beat queue lets the front take beats while the back works or stalls.
// Reset is synchronous, active low; it empties the queue and drops m_tvalid.
`default_nettype none
module line_segment_clipper (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // start_x, start_y, end_x, end_y, colour
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // clip_start_x, clip_start_y, clip_end_x,
                                        // clip_end_y, colour_out
    output logic [0:0]       m_tuser,   // accepted
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    lsc_pkg::window_t win_reg;
    lsc_pkg::entry_t  push_entry, head;
    logic             q_push, q_pop, q_full, q_empty;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg.left   <= 8'd0;
            win_reg.right  <= 8'd255;
            win_reg.top    <= 8'd0;
            win_reg.bottom <= 8'd191;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
            unique case (paddr[3:2])
                lsc_pkg::REG_LEFT:   win_reg.left   <= pwdata[7:0];
                lsc_pkg::REG_RIGHT:  win_reg.right  <= pwdata[7:0];
                lsc_pkg::REG_TOP:    win_reg.top    <= pwdata[7:0];
                lsc_pkg::REG_BOTTOM: win_reg.bottom <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            lsc_pkg::REG_LEFT:   prdata = {24'd0, win_reg.left};
            lsc_pkg::REG_RIGHT:  prdata = {24'd0, win_reg.right};
            lsc_pkg::REG_TOP:    prdata = {24'd0, win_reg.top};
            lsc_pkg::REG_BOTTOM: prdata = {24'd0, win_reg.bottom};
            default:             prdata = 32'd0;
        endcase
    end

    lsc_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .win      (win_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    lsc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    lsc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .win      (win_reg),
        .head     (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire

/* rtl/lsc_checker.sv */
`default_nettype none
module lsc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic [0:0]  m_tuser
);
    a_valid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("m_tvalid dropped");
    a_data_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata)) else $error("m_tdata changed");
    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[31:0] == 32'd0)
        else $error("rejected beat carries coordinates");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid) else $error("m_tvalid after reset");
endmodule

bind line_segment_clipper lsc_checker u_lsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
